// ===== hw/rtl/qrm_pkg.sv =====
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared widths, constants and types for the quaternion to rotation matrix
// pipeline.
// ----------------------------------------------------------------------------
package qrm_pkg;

	localparam int COMP_W = 16;            // Q1.14 component width
	localparam int PROD_W = 32;            // Q2.28 product width
	localparam int NUM_W  = 35;            // signed numerator width
	localparam int DEN_W  = 33;            // squared length, at most 2^32
	localparam int FRAC_W = 14;            // fraction bits of the result
	localparam int QUO_W  = 15;            // quotient bits, result at most 2^14
	localparam int DVD_W  = DEN_W + FRAC_W; // rounded dividend width
	localparam int ENTRIES = 9;

	localparam logic [QUO_W-1:0] ONE_Q14 = QUO_W'(16384);

	// Numerator and squared length of one matrix entry
	typedef struct packed {
		logic signed [NUM_W-1:0] num;
		logic        [DEN_W-1:0] den;
	} qrm_frac_t;

endpackage

// ===== hw/rtl/qrm_front.sv =====
// ----------------------------------------------------------------------------
// qrm_front
// Two pipeline stages: component products, then squared length and the nine
// numerators of the rotation matrix.
// ----------------------------------------------------------------------------
module qrm_front (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [qrm_pkg::COMP_W-1:0]   quat_w,
	input  logic signed [qrm_pkg::COMP_W-1:0]   quat_x,
	input  logic signed [qrm_pkg::COMP_W-1:0]   quat_y,
	input  logic signed [qrm_pkg::COMP_W-1:0]   quat_z,
	output qrm_pkg::qrm_frac_t                  frac [qrm_pkg::ENTRIES]
);
	import qrm_pkg::*;

	logic signed [PROD_W-1:0] ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [PROD_W-1:0] xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;
	logic signed [NUM_W-1:0]  num_c [ENTRIES];
	logic        [DEN_W-1:0]  l2_c;
	qrm_frac_t                frac_s2 [ENTRIES];

	// Stage 1: multiply component pairs
	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1 <= quat_w * quat_w;
			xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y;
			zz_s1 <= quat_z * quat_z;
			xy_s1 <= quat_x * quat_y;
			wz_s1 <= quat_w * quat_z;
			xz_s1 <= quat_x * quat_z;
			wy_s1 <= quat_w * quat_y;
			yz_s1 <= quat_y * quat_z;
			wx_s1 <= quat_w * quat_x;
		end
	end

	// Form squared length and numerators, row by row
	always_comb begin
		l2_c = DEN_W'(ww_s1) + DEN_W'(xx_s1) + DEN_W'(yy_s1) + DEN_W'(zz_s1);
		num_c[0] = NUM_W'(ww_s1) + NUM_W'(xx_s1) - NUM_W'(yy_s1) - NUM_W'(zz_s1);
		num_c[1] = (NUM_W'(xy_s1) - NUM_W'(wz_s1)) <<< 1;
		num_c[2] = (NUM_W'(xz_s1) + NUM_W'(wy_s1)) <<< 1;
		num_c[3] = (NUM_W'(xy_s1) + NUM_W'(wz_s1)) <<< 1;
		num_c[4] = NUM_W'(ww_s1) - NUM_W'(xx_s1) + NUM_W'(yy_s1) - NUM_W'(zz_s1);
		num_c[5] = (NUM_W'(yz_s1) - NUM_W'(wx_s1)) <<< 1;
		num_c[6] = (NUM_W'(xz_s1) - NUM_W'(wy_s1)) <<< 1;
		num_c[7] = (NUM_W'(yz_s1) + NUM_W'(wx_s1)) <<< 1;
		num_c[8] = NUM_W'(ww_s1) - NUM_W'(xx_s1) - NUM_W'(yy_s1) + NUM_W'(zz_s1);
	end

	// Stage 2: hold numerators with the shared denominator
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < ENTRIES; i++) begin
				frac_s2[i].num <= num_c[i];
				frac_s2[i].den <= l2_c;
			end
		end
	end

	assign frac = frac_s2;

endmodule

// ===== hw/rtl/qrm_div.sv =====
// ----------------------------------------------------------------------------
// qrm_div
// Pipelined restoring divider for one matrix entry: rounds 2^14*|num|/den
// half away from zero, one quotient bit per stage, then applies the sign.
// ----------------------------------------------------------------------------
module qrm_div (
	input  logic                               clk,
	input  logic                               en,
	input  qrm_pkg::qrm_frac_t                 frac,
	output logic signed [qrm_pkg::COMP_W-1:0]  res
);
	import qrm_pkg::*;

	logic [NUM_W-1:0] mag_c;
	logic [DVD_W-1:0] dvd_c;

	logic [DEN_W-1:0] rem_s [QUO_W+1];
	logic [QUO_W-1:0] low_s [QUO_W+1];
	logic [QUO_W-1:0] quo_s [QUO_W+1];
	logic [DEN_W-1:0] den_s [QUO_W+1];
	logic             neg_s [QUO_W+1];
	logic             zero_s [QUO_W+1];
	logic signed [COMP_W-1:0] res_q;

	// Build the rounded dividend from the numerator magnitude
	always_comb begin
		mag_c = frac.num[NUM_W-1] ? NUM_W'(-frac.num) : NUM_W'(frac.num);
		dvd_c = (DVD_W'(mag_c[DEN_W-1:0]) << FRAC_W) + DVD_W'(frac.den >> 1);
	end

	// Entry stage: split dividend into initial remainder and pending bits
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= DEN_W'(dvd_c[DVD_W-1:QUO_W]);
			low_s[0]  <= dvd_c[QUO_W-1:0];
			quo_s[0]  <= '0;
			den_s[0]  <= frac.den;
			neg_s[0]  <= frac.num[NUM_W-1];
			zero_s[0] <= (frac.den == '0);
		end
	end

	// Divide stages: shift in one dividend bit, compare and subtract
	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [DEN_W:0] trial;
		logic           ge;

		always_comb begin
			trial = {rem_s[k], low_s[k][QUO_W-1]};
			ge    = (trial >= {1'b0, den_s[k]});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? DEN_W'(trial - {1'b0, den_s[k]}) : DEN_W'(trial);
				low_s[k+1]  <= low_s[k] << 1;
				quo_s[k+1]  <= {quo_s[k][QUO_W-2:0], ge};
				den_s[k+1]  <= den_s[k];
				neg_s[k+1]  <= neg_s[k];
				zero_s[k+1] <= zero_s[k];
			end
		end
	end

	// Output stage: clamp, apply sign, force zero for a null quaternion
	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s[QUO_W]) begin
				res_q <= '0;
			end else begin
				if (neg_s[QUO_W]) begin
					res_q <= -$signed(COMP_W'((quo_s[QUO_W] > ONE_Q14) ? ONE_Q14
						: quo_s[QUO_W]));
				end else begin
					res_q <= $signed(COMP_W'((quo_s[QUO_W] > ONE_Q14) ? ONE_Q14
						: quo_s[QUO_W]));
				end
			end
		end
	end

	assign res = res_q;

endmodule

// ===== hw/rtl/quaternion_to_rotation_matrix.sv =====
// Pipeline: 2 front stages, one divider entry stage, 15 divide stages and one
// output stage between input transaction and result.
// Throughput: one quaternion per cycle; the whole pipeline advances together
// and holds while a finished result is stalled at the output.
// Reset: arst_n clears all valid bits asynchronously; data registers keep state.
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Converts a Q1.14 quaternion into its normalized 3x3 rotation matrix in Q1.14.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [qrm_pkg::COMP_W-1:0]  quat_w,
	input  logic signed [qrm_pkg::COMP_W-1:0]  quat_x,
	input  logic signed [qrm_pkg::COMP_W-1:0]  quat_y,
	input  logic signed [qrm_pkg::COMP_W-1:0]  quat_z,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [qrm_pkg::COMP_W-1:0]  r00,
	output logic signed [qrm_pkg::COMP_W-1:0]  r01,
	output logic signed [qrm_pkg::COMP_W-1:0]  r02,
	output logic signed [qrm_pkg::COMP_W-1:0]  r10,
	output logic signed [qrm_pkg::COMP_W-1:0]  r11,
	output logic signed [qrm_pkg::COMP_W-1:0]  r12,
	output logic signed [qrm_pkg::COMP_W-1:0]  r20,
	output logic signed [qrm_pkg::COMP_W-1:0]  r21,
	output logic signed [qrm_pkg::COMP_W-1:0]  r22,
	output logic                               zero_error
);
	import qrm_pkg::*;

	localparam int LAT = 2 + 1 + QUO_W + 1;

	logic                      adv;
	logic [LAT-1:0]            vld_q;
	logic                      zero_s1, zero_s2;
	logic [LAT-3:0]            zero_q;
	qrm_frac_t                 frac [ENTRIES];
	logic signed [COMP_W-1:0]  res [ENTRIES];

	// Advance whenever the output slot is free or being taken
	assign adv      = !(vld_q[LAT-1] && out_stall);
	assign in_stall = !adv;

	// Shift valid bits along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// Track the zero-length flag alongside the divider
	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s1 <= (quat_w == '0) && (quat_x == '0) && (quat_y == '0)
				&& (quat_z == '0);
			zero_s2 <= zero_s1;
			zero_q  <= {zero_q[LAT-4:0], zero_s2};
		end
	end

	qrm_front u_front (
		.clk    (clk),
		.en     (adv),
		.quat_w (quat_w),
		.quat_x (quat_x),
		.quat_y (quat_y),
		.quat_z (quat_z),
		.frac   (frac)
	);

	for (genvar i = 0; i < ENTRIES; i++) begin : g_div
		qrm_div u_div (
			.clk  (clk),
			.en   (adv),
			.frac (frac[i]),
			.res  (res[i])
		);
	end

	assign out_valid  = vld_q[LAT-1];
	assign zero_error = zero_q[LAT-3];
	assign r00 = res[0];
	assign r01 = res[1];
	assign r02 = res[2];
	assign r10 = res[3];
	assign r11 = res[4];
	assign r12 = res[5];
	assign r20 = res[6];
	assign r21 = res[7];
	assign r22 = res[8];

	// A null quaternion yields a zero matrix; checked on r00, r11, r22 and r12
	a_zero_matrix: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_error |-> r00 == '0 && r11 == '0 && r22 == '0 && r12 == '0)
		else $error("zero quaternion gave nonzero matrix");

	// Diagonal entries r00 and r11 stay within unit range
	a_diag_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> r00 >= -16384 && r00 <= 16384 && r11 >= -16384 && r11 <= 16384)
		else $error("diagonal entry out of range");

	// Off-diagonal entries r01 and r21 stay within unit range
	a_off_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> r01 >= -16384 && r01 <= 16384 && r21 >= -16384 && r21 <= 16384)
		else $error("off-diagonal entry out of range");

endmodule

// ===== verif/quaternion_to_rotation_matrix_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_tb
// Drives Q1.14 quaternions through the rotation matrix block and checks every
// matrix against an exact rounded ratio model, under random valid and stall
// bursts.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_tb;

	import qrm_pkg::*;

	localparam int LATENCY   = 19;
	localparam int N_RANDOM  = 1400;
	localparam int MAX_CYCLE = 400000;

	typedef logic signed [COMP_W-1:0] comp_t;

	typedef struct packed {
		comp_t w, x, y, z;
	} quat_t;

	typedef struct packed {
		comp_t [8:0] ent;   // r00..r22 in row-major order, entry 0 at the low end
		logic        zero_err;
	} matrix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	comp_t quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	comp_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic zero_error;

	quat_t   pending_quats[$];
	matrix_t expected_mats[$];
	int      errors = 0;
	int      cycle = 0;
	int      matched = 0;
	int      zero_seen = 0;
	bit      quiet = 1'b0;    // no idling in the last part
	bit      hold_tx = 1'b0;  // sender pause until drained
	int      in_gap = 0, out_gap = 0;

	quaternion_to_rotation_matrix dut (.*);

	always #5 clk = ~clk;

	// round(2^14 * num / den), half away from zero, magnitude clamped to 2^14
	function automatic comp_t rounded_ratio(longint num, longint den);
		longint mag, q;
		mag = (num < 0) ? -num : num;
		q = (mag * 16384 + den / 2) / den;
		if (q > 16384)
			q = 16384;
		return comp_t'((num < 0) ? -q : q);
	endfunction

	function automatic matrix_t rotation_of(quat_t q);
		matrix_t m;
		longint w, x, y, z, ww, xx, yy, zz, len2;
		longint num[9];
		w = q.w; x = q.x; y = q.y; z = q.z;
		ww = w * w; xx = x * x; yy = y * y; zz = z * z;
		len2 = ww + xx + yy + zz;
		m = '0;
		if (len2 == 0) begin
			m.zero_err = 1'b1;
			return m;
		end
		num[0] = ww + xx - yy - zz;
		num[1] = 2 * (x * y - w * z);
		num[2] = 2 * (x * z + w * y);
		num[3] = 2 * (x * y + w * z);
		num[4] = ww - xx + yy - zz;
		num[5] = 2 * (y * z - w * x);
		num[6] = 2 * (x * z - w * y);
		num[7] = 2 * (y * z + w * x);
		num[8] = ww - xx - yy + zz;
		for (int i = 0; i < 9; i++)
			m.ent[i] = rounded_ratio(num[i], len2);
		return m;
	endfunction

	function automatic comp_t rand_comp();
		case ($urandom_range(0, 5))
			0: return comp_t'($urandom_range(0, 65535));
			1: return comp_t'($urandom_range(0, 32) - 16);
			2: return $urandom_range(0, 1) ? comp_t'(16'sh7fff) : comp_t'(16'sh8000);
			default: return comp_t'($urandom_range(0, 32768) - 16384);
		endcase
	endfunction

	// Drive: advance on acceptance, idle in random bursts
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (arst_n && !(in_valid && in_stall)) begin
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (!hold_tx && pending_quats.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
				in_valid <= 1'b0;
				in_gap <= $urandom_range(0, 5);
			end else if (!hold_tx && pending_quats.size() > 0) begin
				quat_t q;
				q = pending_quats.pop_front();
				expected_mats.push_back(rotation_of(q));
				in_valid <= 1'b1;
				quat_w <= q.w; quat_x <= q.x; quat_y <= q.y; quat_z <= q.z;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall output in random bursts
	always @(posedge clk) begin
		if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			out_gap <= $urandom_range(0, 5);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Check each result transaction against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			matrix_t exp_m;
			comp_t got[9];
			got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
			if (expected_mats.size() == 0) begin
				$display("%0t unexpected result transaction", $time);
				errors++;
			end else begin
				exp_m = expected_mats.pop_front();
				for (int i = 0; i < 9; i++)
					if (got[i] !== exp_m.ent[i]) begin
						$display("%0t r%0d%0d expected %0d actual %0d", $time, i / 3, i % 3,
							exp_m.ent[i], got[i]);
						errors++;
					end
				if (zero_error !== exp_m.zero_err) begin
					$display("%0t zero_error expected %0b actual %0b", $time,
						exp_m.zero_err, zero_error);
					errors++;
				end
				matched++;
				if (exp_m.zero_err)
					zero_seen++;
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		if (cycle > MAX_CYCLE) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		quat_t q;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: zero, unit axes, extremes, tiny and non-unit lengths
		pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
		pending_quats.push_back('{16'sd16384, 16'sd0, 16'sd0, 16'sd0});
		pending_quats.push_back('{16'sd0, 16'sd16384, 16'sd0, 16'sd0});
		pending_quats.push_back('{16'sd0, 16'sd0, 16'sd16384, 16'sd0});
		pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd16384});
		pending_quats.push_back('{-16'sd16384, 16'sd0, 16'sd0, 16'sd0});
		pending_quats.push_back('{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192});
		pending_quats.push_back('{16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192});
		pending_quats.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
		pending_quats.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
		pending_quats.push_back('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
		pending_quats.push_back('{16'sh8000, 16'sd0, 16'sd0, 16'sd0});
		pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd1});
		pending_quats.push_back('{16'sd1, -16'sd1, 16'sd0, 16'sd0});
		pending_quats.push_back('{16'sd3, 16'sd0, 16'sd0, 16'sd4});
		pending_quats.push_back('{16'sd11585, 16'sd0, 16'sd11585, 16'sd0});
		pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
		pending_quats.push_back('{-16'sd1, -16'sd1, -16'sd1, -16'sd1});
		pending_quats.push_back('{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa});
		wait (pending_quats.size() == 0 && expected_mats.size() == 0);

		// Random, with one pause until the pipeline drains
		for (int n = 0; n < N_RANDOM; n++) begin
			q.w = rand_comp(); q.x = rand_comp(); q.y = rand_comp(); q.z = rand_comp();
			if ($urandom_range(0, 49) == 0)
				q = '0;
			pending_quats.push_back(q);
			if (n == N_RANDOM / 2) begin
				wait (pending_quats.size() == 0);
				@(posedge clk);
				hold_tx <= 1'b1;
				wait (expected_mats.size() == 0);
				@(posedge clk);
				hold_tx <= 1'b0;
			end
		end

		// Stop idling once only the last stretch is left to send
		wait (pending_quats.size() <= 200);
		quiet = 1'b1;

		wait (pending_quats.size() == 0 && expected_mats.size() == 0);
		repeat (LATENCY + 5) @(posedge clk);

		$display("covered %0d matrices, %0d zero-length inputs, with bursts of idle and stall",
			matched, zero_seen);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
